/* rtl/hsvrgb_pkg.sv */
// Package with the hue sector type, constants and decode functions for the HSV converter.
`default_nettype none

package hsvrgb_pkg;

	localparam logic [7:0] FullScale  = 8'd255;
	localparam logic [8:0] SectorSpan = 9'd85;

	typedef enum logic [2:0] {
		SEC_0,
		SEC_1,
		SEC_2,
		SEC_3,
		SEC_4,
		SEC_5
	} sector_t;

	// Stage one payload: decoded hue and the untouched saturation and value.
	typedef struct packed {
		logic        gray;
		sector_t     sector;
		logic [7:0]  rem;
		logic [7:0]  sat;
		logic [7:0]  val;
	} hue_dec_t;

	// Shaded levels with what the final select needs.
	typedef struct packed {
		logic        gray;
		sector_t     sector;
		logic [7:0]  val;
		logic [7:0]  p;
		logic [7:0]  q;
		logic [7:0]  t;
	} shade_t;

	// Sector is floor(hue * 6 / 255); the thresholds are the rounded-up multiples of 42.5.
	// Full hue wraps around to the first sector.
	function automatic sector_t hue_sector(input logic [7:0] h);
		sector_t s;
		if (h == FullScale)   s = SEC_0;
		else if (h >= 8'd213) s = SEC_5;
		else if (h >= 8'd170) s = SEC_4;
		else if (h >= 8'd128) s = SEC_3;
		else if (h >= 8'd85)  s = SEC_2;
		else if (h >= 8'd43)  s = SEC_1;
		else                  s = SEC_0;
		return s;
	endfunction

	function automatic logic [8:0] sector_base(input sector_t s);
		logic [8:0] b;
		case (s)
			SEC_0:   b = 9'd0;
			SEC_1:   b = SectorSpan;
			SEC_2:   b = 9'd170;
			SEC_3:   b = 9'd255;
			SEC_4:   b = 9'd340;
			SEC_5:   b = 9'd425;
			default: b = 9'd0;
		endcase
		return b;
	endfunction

	// Position inside the sector: three times the distance of twice the hue from the
	// sector start. That distance stays below 85, so the product fits in eight bits.
	function automatic logic [7:0] hue_rem(input logic [7:0] h, input sector_t s);
		logic [8:0] d;
		logic [8:0] m;
		d = {h, 1'b0} - sector_base(s);
		m = d + {d[7:0], 1'b0};
		if (h == FullScale) m = 9'd0;
		return m[7:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/hsvrgb_scale8.sv */
// Eight-bit fixed-point scale: product of two bytes, upper byte kept.
`default_nettype none

module hsvrgb_scale8 import hsvrgb_pkg::*; (
	input  wire logic [7:0] a,
	input  wire logic [7:0] b,
	output logic [7:0]      y
);

	logic [15:0] prod;

	assign prod = a * b;
	assign y    = prod[15:8];

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb565_converter_unit.sv */
// Top level of the pipelined HSV to byte-swapped RGB565 pixel converter.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------
//   hsv     | hsv_valid/hsv_ready | hue, saturation, brightness (8b)
//   rgb     | rgb_valid/rgb_ready | pixel_word (16b)
//
// Four register stages: hue decode, first products, second products, select and pack.
// A pixel is accepted every cycle while nothing stalls, and its word reaches the output
// from the stage four register.
// The depth is set by the two dependent 8x8 multiplies, one stage each.
// Reset clears only the stage valid bits; the data registers load without reset.
// A stage takes a new item whenever it is empty or its successor moves, so bubbles close up.
`default_nettype none

module hsv_to_rgb565_converter_unit import hsvrgb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hsv_valid,
	output logic             hsv_ready,
	input  wire logic [7:0]  hue,
	input  wire logic [7:0]  saturation,
	input  wire logic [7:0]  brightness,
	output logic             rgb_valid,
	input  wire logic        rgb_ready,
	output logic [15:0]      pixel_word
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        ready_s2, ready_s3, ready_s4;
	hue_dec_t    dec_s1;
	hue_dec_t    dec_s2;
	logic [7:0]  p_s2, sq_s2, st_s2;
	shade_t      shd_s3;
	logic [15:0] pixel_s4;

	logic [7:0]  p_c, sq_c, st_c, q_c, t_c;
	sector_t     sector_c;
	logic [7:0]  r_c, g_c, b_c;
	logic [15:0] rgb565_c;

	assign ready_s4  = !valid_s4 || rgb_ready;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign hsv_ready = !valid_s1 || ready_s2;

	assign sector_c = hue_sector(hue);

	// Stage one: hue decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hsv_ready) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hsv_ready && hsv_valid) begin
			dec_s1.gray   <= (saturation == 8'd0);
			dec_s1.sector <= sector_c;
			dec_s1.rem    <= hue_rem(hue, sector_c);
			dec_s1.sat    <= saturation;
			dec_s1.val    <= brightness;
		end
	end

	// Stage two: p and the saturation-weighted positions.
	hsvrgb_scale8 u_mul_p (.a(dec_s1.val), .b(FullScale - dec_s1.sat), .y(p_c));
	hsvrgb_scale8 u_mul_sq (.a(dec_s1.sat), .b(dec_s1.rem), .y(sq_c));
	hsvrgb_scale8 u_mul_st (.a(dec_s1.sat), .b(FullScale - dec_s1.rem), .y(st_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			dec_s2 <= dec_s1;
			p_s2   <= p_c;
			sq_s2  <= sq_c;
			st_s2  <= st_c;
		end
	end

	// Stage three: q and t.
	hsvrgb_scale8 u_mul_q (.a(dec_s2.val), .b(FullScale - sq_s2), .y(q_c));
	hsvrgb_scale8 u_mul_t (.a(dec_s2.val), .b(FullScale - st_s2), .y(t_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			shd_s3.gray   <= dec_s2.gray;
			shd_s3.sector <= dec_s2.sector;
			shd_s3.val    <= dec_s2.val;
			shd_s3.p      <= p_s2;
			shd_s3.q      <= q_c;
			shd_s3.t      <= t_c;
		end
	end

	// Stage four: pick the triple and pack it.
	always_comb begin
		r_c = shd_s3.val;
		g_c = shd_s3.t;
		b_c = shd_s3.p;
		if (shd_s3.gray) begin
			g_c = shd_s3.val;
			b_c = shd_s3.val;
		end else begin
			case (shd_s3.sector)
				SEC_1: begin
					r_c = shd_s3.q;   g_c = shd_s3.val; b_c = shd_s3.p;
				end
				SEC_2: begin
					r_c = shd_s3.p;   g_c = shd_s3.val; b_c = shd_s3.t;
				end
				SEC_3: begin
					r_c = shd_s3.p;   g_c = shd_s3.q;   b_c = shd_s3.val;
				end
				SEC_4: begin
					r_c = shd_s3.t;   g_c = shd_s3.p;   b_c = shd_s3.val;
				end
				SEC_5: begin
					r_c = shd_s3.val; g_c = shd_s3.p;   b_c = shd_s3.q;
				end
				default: begin
					r_c = shd_s3.val; g_c = shd_s3.t;   b_c = shd_s3.p;
				end
			endcase
		end
	end

	assign rgb565_c = {r_c[7:3], g_c[7:2], b_c[7:3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	// The panel wants the low byte first.
	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			pixel_s4 <= {rgb565_c[7:0], rgb565_c[15:8]};
		end
	end

	assign rgb_valid  = valid_s4;
	assign pixel_word = pixel_s4;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> dec_s1.rem <= 8'd252)
		else $error("sector position out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(dec_s1))
		else $error("stalled stage one item changed");

	a_shade_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> shd_s3.p <= shd_s3.val && shd_s3.q <= shd_s3.val
			&& shd_s3.t <= shd_s3.val)
		else $error("shaded level above value");

endmodule

`default_nettype wire

/* tb/hsv_to_rgb565_converter_unit_test.sv */
// Self-checking testbench for the HSV to byte-swapped RGB565 pixel converter.
`default_nettype none

module hsv_to_rgb565_converter_unit_test import hsvrgb_pkg::*;;

	localparam int CycleLimit = 500000;
	localparam int RandomPixels = 2000;
	localparam int CalmTail = 300;

	logic        clk;
	logic        arst_n;
	logic        hsv_valid;
	logic        hsv_ready;
	logic [7:0]  hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic        rgb_valid;
	logic        rgb_ready;
	logic [15:0] pixel_word;

	logic [15:0] pending_words[$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          calm_tail = 1'b0;

	hsv_to_rgb565_converter_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.pixel_word (pixel_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] scale_by(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] prod;
		prod = a * b;
		return prod[15:8];
	endfunction

	// Expected panel word for one pixel.
	function automatic logic [15:0] hsv_to_panel_word(input logic [7:0] h, input logic [7:0] s,
			input logic [7:0] v);
		int unsigned sec_num;
		int unsigned span;
		sector_t     sec;
		logic [7:0]  rem;
		logic [7:0]  p;
		logic [7:0]  q;
		logic [7:0]  t;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] w;
		sec_num = (h * 6) / 255;
		span = (2 * h - sec_num * 85) * 3;
		rem = span[7:0];
		// Hue at full scale lands one past the last sector and wraps to the first.
		sec = (sec_num >= 6) ? SEC_0 : sector_t'(sec_num[2:0]);
		p = scale_by(v, 8'd255 - s);
		q = scale_by(v, 8'd255 - scale_by(s, rem));
		t = scale_by(v, 8'd255 - scale_by(s, 8'd255 - rem));
		if (s == 8'd0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			case (sec)
				SEC_1: begin r = q; g = v; b = p; end
				SEC_2: begin r = p; g = v; b = t; end
				SEC_3: begin r = p; g = q; b = v; end
				SEC_4: begin r = t; g = p; b = v; end
				SEC_5: begin r = v; g = p; b = q; end
				default: begin r = v; g = t; b = p; end
			endcase
		end
		w = {r[7:3], g[7:2], b[7:3]};
		return {w[7:0], w[15:8]};
	endfunction

	// Called at a rising edge; returns at the rising edge where the item is taken,
	// with valid still high.
	task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
		bit taken;
		taken = 1'b0;
		if (!calm_tail && $urandom_range(0, 5) == 0) begin
			hsv_valid <= 1'b0;
			hue <= 8'($urandom);
			saturation <= 8'($urandom);
			brightness <= 8'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		hsv_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		// Inputs only move at rising edges, so the falling edge shows what the next rising
		// edge will see.
		while (!taken) begin
			@(negedge clk);
			if (hsv_ready) begin
				taken = 1'b1;
				pending_words.push_back(hsv_to_panel_word(h, s, v));
			end
			@(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		hsv_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_gray();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd100, 8'd0, 8'd128);
		send_pixel(8'd200, 8'd0, 8'd7);
	endtask

	task automatic test_sector_edges();
		logic [7:0] edge_hues[14];
		edge_hues = '{8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd127, 8'd128, 8'd169, 8'd170,
			8'd212, 8'd213, 8'd254, 8'd255, 8'd64};
		foreach (edge_hues[i]) send_pixel(edge_hues[i], 8'd255, 8'd255);
		send_pixel(8'd255, 8'd1, 8'd255);
		send_pixel(8'd30, 8'd255, 8'd0);
		send_pixel(8'd150, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd128, 8'd200);
	endtask

	task automatic test_pause_until_empty();
		send_pixel(8'd10, 8'd200, 8'd90);
		send_pixel(8'd190, 8'd90, 8'd240);
		drain_pipeline();
		@(posedge clk);
		send_pixel(8'd230, 8'd170, 8'd33);
	endtask

	task automatic test_random_pixels();
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		int         pick;
		logic [7:0] edge_hues[7];
		logic [7:0] end_values[4];
		edge_hues = '{8'd42, 8'd43, 8'd85, 8'd128, 8'd170, 8'd213, 8'd255};
		end_values = '{8'd0, 8'd1, 8'd254, 8'd255};
		for (int i = 0; i < RandomPixels; i++) begin
			if (i == RandomPixels - CalmTail) calm_tail = 1'b1;
			h = 8'($urandom);
			s = 8'($urandom);
			v = 8'($urandom);
			pick = $urandom_range(0, 9);
			if (pick == 0) s = 8'd0;
			else if (pick == 1) h = edge_hues[$urandom_range(0, 6)];
			else if (pick == 2) begin
				s = end_values[$urandom_range(0, 3)];
				v = end_values[$urandom_range(0, 3)];
			end
			send_pixel(h, s, v);
		end
	endtask

	// Output side: random stall bursts until the calm tail.
	initial begin
		rgb_ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!calm_tail && $urandom_range(0, 5) == 0) begin
				rgb_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(negedge clk) begin
		if (arst_n && rgb_valid && rgb_ready) begin
			if (pending_words.size() == 0) begin
				$error("pixel_word: no item expected, actual %h", pixel_word);
				error_count++;
			end else begin
				if (pixel_word !== pending_words[0]) begin
					$error("pixel_word: expected %h, actual %h", pending_words[0], pixel_word);
					error_count++;
				end
				void'(pending_words.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("hsv_to_rgb565_converter_unit_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		hsv_valid <= 1'b0;
		hue <= 8'd0;
		saturation <= 8'd0;
		brightness <= 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gray();
		test_sector_edges();
		test_pause_until_empty();
		test_random_pixels();
		drain_pipeline();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("hsv_to_rgb565_converter_unit_test: clean");
		end else begin
			$display("hsv_to_rgb565_converter_unit_test: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_scale8.sv
rtl/hsv_to_rgb565_converter_unit.sv
tb/hsv_to_rgb565_converter_unit_test.sv
